FILE: design/bdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque package
// Sizes, opcodes, status codes, the store write port type and the ring
// index helper shared by the deque control and its element store.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int CAPACITY    = 16;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int DATA_W      = 32;
   localparam int OP_W        = 3;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [DATA_W-1:0] data_type;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FIRST  = 3'd2,
      OP_COUNT      = 3'd3,
      OP_SEARCH     = 3'd4,
      OP_REVERSE    = 3'd5,
      OP_CLEAR      = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic     en;
      idx_type  addr;
      data_type data;
   } wr_type;

   // Adds an offset below the capacity to a ring position and wraps it.
   function automatic idx_type ring_add(idx_type base, idx_type offset);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (IDX_W + 1)'(CAPACITY)) begin
         sum = sum - (IDX_W + 1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: design/bdq_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque element store
// Single port write, single port read memory holding the ring of elements.
// Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module bdq_store
   import bdq_pkg::*;
(
   input  wire      clock,
   input  wr_type   wr,
   input  idx_type  rd_addr,
   output data_type rd_data
);

   data_type mem [CAPACITY];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: design/bounded_deque_with_search_reverse_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque with search and reverse
// Ring buffer deque of signed 32-bit values with front and back insert,
// remove first, count, search, reverse by direction flag, and clear.
// ----------------------------------------------------------------------------
// Every operation except search gives its result in the cycle after the
// transfer, and a new transfer can be taken in every cycle while busy is low.
// Search walks the stored run through the memory read port, one entry per
// cycle, and gives its result once the last entry read has been compared (an
// empty list is answered like the other operations); busy is high for that walk.
// The result cannot be stalled. Synchronous reset empties the list.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_reverse_unit
   import bdq_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [OP_W-1:0]              req_opcode,
   input  wire  signed [DATA_W-1:0]     req_value,
   output logic                         rsp_valid,
   output logic [COUNT_OUT_W-1:0]       rsp_element_count,
   output logic                         rsp_found,
   output logic [STATUS_W-1:0]          rsp_status
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type  state_ff,  state_in;
   idx_type    first_ff,  first_in;
   cnt_type    count_ff,  count_in;
   logic       rev_ff,    rev_in;
   cnt_type    issue_ff,  issue_in;
   logic       pend_ff,   pend_in;
   logic       hit_ff,    hit_in;
   data_type   key_ff,    key_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_found_ff, rsp_found_in;
   status_type             rsp_status_ff, rsp_status_in;

   wr_type   wr;
   idx_type  rd_addr;
   data_type rd_data;
   logic     accept;

   bdq_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff == ST_SCAN);
   assign accept = start && !busy;

   assign rd_addr = ring_add(first_ff, issue_ff[IDX_W-1:0]);

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      rev_in        = rev_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      hit_in        = hit_ff;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_count_in  = rsp_count_ff;
      rsp_found_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      wr.en         = 1'b0;
      wr.addr       = ring_add(first_ff, count_ff[IDX_W-1:0]);
      wr.data       = data_type'(req_value);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (op_type'(req_opcode))
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (count_ff >= cnt_type'(CAPACITY)) begin
                        rsp_status_in = STATUS_FULL;
                     end else if ((op_type'(req_opcode) == OP_PUSH_FRONT) == !rev_ff) begin
                        first_in = ring_add(first_ff, idx_type'(CAPACITY - 1));
                        wr.en    = 1'b1;
                        wr.addr  = first_in;
                        count_in = count_ff + cnt_type'(1);
                     end else begin
                        wr.en    = 1'b1;
                        count_in = count_ff + cnt_type'(1);
                     end
                  end
                  OP_POP_FIRST: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else if (!rev_ff) begin
                        first_in = ring_add(first_ff, idx_type'(1));
                        count_in = count_ff - cnt_type'(1);
                     end else begin
                        count_in = count_ff - cnt_type'(1);
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        key_in       = data_type'(req_value);
                        issue_in     = '0;
                        pend_in      = 1'b0;
                        hit_in       = 1'b0;
                     end
                  end
                  OP_REVERSE: begin
                     rev_in = !rev_ff;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     first_in = '0;
                     rev_in   = 1'b0;
                  end
                  OP_COUNT: begin
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = COUNT_OUT_W'(count_in);
            end
         end
         ST_SCAN: begin
            hit_in = hit_ff || (pend_ff && (rd_data == key_ff));
            if (issue_ff != count_ff) begin
               issue_in = issue_ff + cnt_type'(1);
               pend_in  = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_found_in = hit_ff;
                  rsp_count_in = COUNT_OUT_W'(count_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_ff      <= '0;
         count_ff      <= '0;
         rev_ff        <= 1'b0;
         issue_ff      <= '0;
         pend_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_count_ff  <= '0;
         rsp_found_ff  <= 1'b0;
         rsp_status_ff <= STATUS_OK;
      end else begin
         state_ff      <= state_in;
         first_ff      <= first_in;
         count_ff      <= count_in;
         rev_ff        <= rev_in;
         issue_ff      <= issue_in;
         pend_ff       <= pend_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_status_ff <= rsp_status_in;
      end
      key_ff <= key_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_status        = rsp_status_ff;

   // The stored count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(CAPACITY))
      else $error("element count above capacity");

   // Every transfer other than search is answered in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode != OP_SEARCH)) |=> rsp_valid)
      else $error("missing result after transfer");

   // A result is never shown while a search walk is still running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe during search walk");

   // A hit is only reported with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_found |-> (rsp_valid && (rsp_status == STATUS_OK)))
      else $error("found flag with bad status");

endmodule
`default_nettype wire
